FILE: rtl/core/grf_pkg.sv
`default_nettype none
package grf_pkg;

   // Configuration register indexes.
   localparam logic REG_PEAK_MAGNITUDE  = 1'b0;
   localparam logic REG_SPREAD_VARIANCE = 1'b1;

   localparam int unsigned COORD_W = 32;
   localparam int unsigned VAR_W   = 31;

   localparam logic [VAR_W-1:0] VAR_FLOOR = VAR_W'(66);
   localparam logic [63:0]      D2_FLOOR  = 64'd4295;
   localparam logic [32:0]      Q32_ONE   = 33'h1_0000_0000;

   localparam int unsigned SERIES_TERMS = 12;
   localparam int unsigned QUO_W        = 32;
   localparam int unsigned SQUARINGS    = 4;

   // Stage map of the pipeline.
   localparam int unsigned ST_DIV   = 4;
   localparam int unsigned ST_SER   = ST_DIV + QUO_W;
   localparam int unsigned ST_SQ    = ST_SER + 2 * SERIES_TERMS;
   localparam int unsigned ST_MUL   = ST_SQ + SQUARINGS;
   localparam int unsigned ST_OUT   = ST_MUL + 1;
   localparam int unsigned NUM_ST   = ST_OUT + 1;

   // Exact division of a 32-bit value by k: floor(p * DIV_MAGIC[k] / 2^DIV_SHIFT[k]).
   localparam logic [32:0] DIV_MAGIC [1:12] = '{
      33'd4294967296, 33'd4294967296, 33'd5726623062, 33'd4294967296,
      33'd6871947674, 33'd5726623062, 33'd4908534053, 33'd4294967296,
      33'd7635497416, 33'd6871947674, 33'd6247225158, 33'd5726623062
   };
   localparam int unsigned DIV_SHIFT [1:12] = '{
      32, 33, 34, 34, 35, 35, 35, 35, 36, 36, 36, 36
   };

endpackage
`default_nettype wire

FILE: rtl/core/gaussian_radial_falloff_core.sv
`default_nettype none
// Gaussian radial falloff: each request carries an influence center and a point in the xz
// plane (signed Q16.16) and yields one response, peak_magnitude * exp(-d2 / (2 * variance)),
// signed Q16.16. The block is a fully pipelined datapath of 66 register stages: a request is
// taken in every cycle unless the pipeline is stalled, so throughput is one point per clock
// when not stalled. Most of the depth is the 32-stage restoring divider that forms the
// exponent argument, the 24 stages of the 12-term series (a multiply and an exact constant
// division per term) and the four squaring stages. Backpressure on the response side
// stalls the whole pipeline in place; nothing is dropped or repeated.
// Configuration writes must only happen while the pipeline is empty.
module gaussian_radial_falloff_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // center_x [31:0], center_z [63:32], point_x [95:64], point_z [127:96]
   input  wire logic [127:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // falloff_value [31:0]
   output logic [31:0]      rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_wdata
);
   import grf_pkg::*;

   logic [31:0]      peak_ff, peak_in;
   logic [VAR_W-1:0] var_ff, var_in;
   logic [VAR_W-1:0] vsel;
   logic             adv;
   logic [NUM_ST-1:0] vld_ff, vld_in;

   // Configuration registers.
   always_comb begin
      peak_in = peak_ff;
      var_in  = var_ff;
      if (csr_we) begin
         case (csr_index)
            REG_PEAK_MAGNITUDE:  peak_in = csr_wdata;
            REG_SPREAD_VARIANCE: var_in  = csr_wdata[VAR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff <= 32'd65536;
         var_ff  <= VAR_W'(65536);
      end else begin
         peak_ff <= peak_in;
         var_ff  <= var_in;
      end
   end

   // A zero variance is replaced by its floor of about 0.001.
   assign vsel = (var_ff == '0) ? VAR_FLOOR : var_ff;

   // The whole pipeline advances together unless the output register is full and held.
   assign adv        = !vld_ff[NUM_ST-1] || rsp_tready;
   assign req_tready = adv;
   assign vld_in     = {vld_ff[NUM_ST-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // Stage 0: absolute coordinate differences.
   logic [32:0] dx, dz;
   logic [31:0] ax_ff, az_ff, ax_in, az_in;
   assign dx    = {req_tdata[31], req_tdata[31:0]} - {req_tdata[95], req_tdata[95:64]};
   assign dz    = {req_tdata[63], req_tdata[63:32]} - {req_tdata[127], req_tdata[127:96]};
   assign ax_in = dx[32] ? 32'(-dx) : dx[31:0];
   assign az_in = dz[32] ? 32'(-dz) : dz[31:0];

   // Stage 1: squares.
   logic [63:0] sx_ff, sz_ff, sx_in, sz_in;
   assign sx_in = 64'(ax_ff) * 64'(ax_ff);
   assign sz_in = 64'(az_ff) * 64'(az_ff);

   // Stage 2: saturating sum with the zero-distance floor, and the exponent limit v * 12 * 2^17.
   logic [64:0] dsum;
   logic [63:0] d2_ff, d2_in;
   logic [51:0] lim_ff, lim_in;
   assign dsum   = {1'b0, sx_ff} + {1'b0, sz_ff};
   assign d2_in  = dsum[64] ? '1 : ((dsum[63:0] == '0) ? D2_FLOOR : dsum[63:0]);
   assign lim_in = (52'(vsel) << 20) + (52'(vsel) << 19);

   // Stage 3: limit compare and divider setup. The dividend is d2 * 2^11; its top part is
   // below v whenever the limit is not reached, so the quotient fits in 32 bits.
   logic big_in;
   assign big_in = d2_ff >= 64'(lim_ff);

   logic [VAR_W-1:0] rem_ff [0:QUO_W];
   logic [31:0]      low_ff [0:QUO_W];
   logic [31:0]      quo_ff [0:QUO_W];
   logic             dbig_ff [0:QUO_W];

   always_ff @(posedge clock) begin
      if (adv) begin
         ax_ff      <= ax_in;
         az_ff      <= az_in;
         sx_ff      <= sx_in;
         sz_ff      <= sz_in;
         d2_ff      <= d2_in;
         lim_ff     <= lim_in;
         dbig_ff[0] <= big_in;
         rem_ff[0]  <= big_in ? '0 : d2_ff[51:21];
         low_ff[0]  <= {d2_ff[20:0], 11'b0};
         quo_ff[0]  <= '0;
      end
   end

   // Restoring divider, one quotient bit per stage.
   for (genvar i = 0; i < QUO_W; i++) begin : g_div
      logic [VAR_W:0]   trial;
      logic             fits;
      logic [VAR_W-1:0] rem_in;
      assign trial  = {rem_ff[i], low_ff[i][31]};
      assign fits   = trial >= {1'b0, vsel};
      assign rem_in = fits ? VAR_W'(trial - {1'b0, vsel}) : trial[VAR_W-1:0];
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[i+1]  <= rem_in;
            low_ff[i+1]  <= {low_ff[i][30:0], 1'b0};
            quo_ff[i+1]  <= {quo_ff[i][30:0], fits};
            dbig_ff[i+1] <= dbig_ff[i];
         end
      end
   end

   // Horner series for exp(-g) in Q.32, two stages per term: g*t, then exact divide by k.
   logic [31:0] hp_ff  [0:SERIES_TERMS-1];
   logic [31:0] hag_ff [0:SERIES_TERMS-1];
   logic        hab_ff [0:SERIES_TERMS-1];
   logic [32:0] ht_ff  [0:SERIES_TERMS-1];
   logic [31:0] hbg_ff [0:SERIES_TERMS-1];
   logic        hbb_ff [0:SERIES_TERMS-1];

   for (genvar j = 0; j < SERIES_TERMS; j++) begin : g_ser
      localparam int unsigned K = SERIES_TERMS - j;
      logic [32:0] t_src;
      logic [31:0] g_src;
      logic        b_src;
      logic [64:0] gt;
      logic [64:0] pm;
      logic [31:0] qk;
      logic [32:0] t_in;
      if (j == 0) begin : g_first
         assign t_src = Q32_ONE;
         assign g_src = quo_ff[QUO_W];
         assign b_src = dbig_ff[QUO_W];
      end else begin : g_next
         assign t_src = ht_ff[j-1];
         assign g_src = hbg_ff[j-1];
         assign b_src = hbb_ff[j-1];
      end
      assign gt   = 65'(g_src) * 65'(t_src);
      assign pm   = 65'(hp_ff[j]) * 65'(DIV_MAGIC[K]);
      assign qk   = 32'(pm >> DIV_SHIFT[K]);
      assign t_in = Q32_ONE - {1'b0, qk};
      always_ff @(posedge clock) begin
         if (adv) begin
            hp_ff[j]  <= gt[63:32];
            hag_ff[j] <= g_src;
            hab_ff[j] <= b_src;
            ht_ff[j]  <= t_in;
            hbg_ff[j] <= hag_ff[j];
            hbb_ff[j] <= hab_ff[j];
         end
      end
   end

   // Four squarings raise exp(-a/16) to exp(-a); 1.0 stays 1.0.
   logic [32:0] sq_ff  [0:SQUARINGS-1];
   logic        sqb_ff [0:SQUARINGS-1];
   for (genvar n = 0; n < SQUARINGS; n++) begin : g_sq
      logic [32:0] src;
      logic        bsrc;
      logic [63:0] prod;
      if (n == 0) begin : g_first
         assign src  = ht_ff[SERIES_TERMS-1];
         assign bsrc = hbb_ff[SERIES_TERMS-1];
      end else begin : g_next
         assign src  = sq_ff[n-1];
         assign bsrc = sqb_ff[n-1];
      end
      assign prod = 64'(src[31:0]) * 64'(src[31:0]);
      always_ff @(posedge clock) begin
         if (adv) begin
            sq_ff[n]  <= src[32] ? Q32_ONE : {1'b0, prod[63:32]};
            sqb_ff[n] <= bsrc;
         end
      end
   end

   // Magnitude scaling, truncated toward zero.
   logic [16:0] e_q16;
   logic [31:0] mabs;
   logic [48:0] mprod;
   logic [31:0] mag_ff, mag_in;
   logic        neg_ff;
   logic [31:0] rsp_data_ff, rsp_data_in;
   assign e_q16       = sqb_ff[SQUARINGS-1] ? '0 : sq_ff[SQUARINGS-1][32:16];
   assign mabs        = peak_ff[31] ? 32'(-peak_ff) : peak_ff;
   assign mprod       = 49'(mabs) * 49'(e_q16);
   assign mag_in      = mprod[47:16];
   assign rsp_data_in = neg_ff ? 32'(-mag_ff) : mag_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         mag_ff      <= mag_in;
         neg_ff      <= peak_ff[31];
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = vld_ff[NUM_ST-1];
   assign rsp_tdata  = rsp_data_ff;

   // The final divider remainder stays below the divisor.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_SER-1] |-> rem_ff[QUO_W] < vsel)
      else $error("divider remainder out of range");

   // The series result lies in 1 .. 2^32.
   a_series_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_SQ-1] |-> (ht_ff[SERIES_TERMS-1] <= Q32_ONE && ht_ff[SERIES_TERMS-1] != '0))
      else $error("series term out of range");

   // A stall freezes every valid bit.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline moved while stalled");

   // A response past the exponent limit carries zero.
   a_big_zero: assert property (@(posedge clock) disable iff (reset)
      (adv && vld_ff[ST_MUL-1] && sqb_ff[SQUARINGS-1]) |=> mag_ff == '0)
      else $error("large exponent gave nonzero result");

endmodule
`default_nettype wire

FILE: tb/grf_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module grf_checker (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [127:0] req_tdata,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [31:0]  rsp_tdata,
   input  wire logic         csr_we,
   input  wire logic         csr_index,
   input  wire logic [31:0]  csr_wdata,
   output int                fail_count,
   output int                pending_count
);
   import grf_pkg::*;

   logic [31:0]      peak_q;
   logic [VAR_W-1:0] spread_q;
   logic [31:0]      falloff_queue [$];

   assign pending_count = falloff_queue.size();

   function automatic logic [63:0] abs_delta(input logic [31:0] a, input logic [31:0] b);
      logic signed [33:0] d;
      d = $signed({{2{a[31]}}, a}) - $signed({{2{b[31]}}, b});
      return d[33] ? 64'(-d) : 64'(d);
   endfunction

   // Exponential in Q32 via a truncated Horner series on d2/(2v)/16, then four squarings.
   function automatic logic [31:0] predict_falloff(input logic [127:0] pt);
      logic [63:0]  ax, az, sx, sz, d2, vv, hi, rr, g, t, e, mabs, prod;
      logic [127:0] wide, lim;
      logic signed [63:0] m;
      ax = abs_delta(pt[31:0], pt[95:64]);
      az = abs_delta(pt[63:32], pt[127:96]);
      sx = ax * ax;
      sz = az * az;
      d2 = sx + sz;
      if (d2 < sx) d2 = '1;
      if (d2 == 0) d2 = 64'd4295;
      vv = (spread_q == 0) ? 64'd66 : 64'(spread_q);
      lim = 128'(vv) * (128'd12 << 17);
      if (128'(d2) >= lim) begin
         e = 0;
      end else begin
         hi = d2 / vv;
         rr = d2 % vv;
         g = (hi << 11) + ((rr << 11) / vv);
         t = 64'h1_0000_0000;
         for (int k = 12; k >= 1; k--) begin
            wide = 128'(g) * 128'(t);
            t = 64'h1_0000_0000 - 64'((wide >> 32) / k);
         end
         for (int i = 0; i < 4; i++)
            t = (t >= 64'h1_0000_0000) ? 64'h1_0000_0000 : (t * t) >> 32;
         e = t >> 16;
      end
      m = 64'($signed(peak_q));
      mabs = (m < 0) ? 64'(-m) : 64'(m);
      prod = (mabs * e) >> 16;
      return (m < 0) ? 32'(-prod) : 32'(prod);
   endfunction

   task automatic report_mismatch(input string what);
      $display("checker: %s at %0t", what, $realtime);
      fail_count++;
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      logic [31:0] want;
      if (reset) begin
         peak_q   <= 32'd65536;
         spread_q <= VAR_W'(65536);
      end else begin
         if (csr_we) begin
            if (csr_index == REG_PEAK_MAGNITUDE) peak_q <= csr_wdata;
            else spread_q <= csr_wdata[VAR_W-1:0];
         end
         if (req_tvalid && req_tready) falloff_queue.push_back(predict_falloff(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (falloff_queue.size() == 0) begin
               report_mismatch("unexpected response");
            end else begin
               want = falloff_queue.pop_front();
               if (want !== rsp_tdata)
                  report_mismatch($sformatf("falloff_value got %h want %h", rsp_tdata, want));
            end
         end
      end
   end

endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps
`default_nettype none
// Stimulus and verdict for the Gaussian falloff core. A checker beside the block predicts
// every response and counts mismatches; this module only drives requests, stalls the
// response side at random and reprograms the two registers while the pipeline is empty.
module tb;
   import grf_pkg::*;

   localparam int PIPE_DEPTH = 66;
   localparam int STALL_LIMIT = 20000;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [31:0]  rsp_tdata;
   logic         csr_we;
   logic         csr_index;
   logic [31:0]  csr_wdata;
   int           fail_count;
   int           pending_count;
   int           idle_cycles;
   bit           stim_done;

   gaussian_radial_falloff_core DUT (.*);

   grf_checker u_checker (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // A coordinate: extremes, small values near the center, or anything at all.
   function automatic logic [31:0] pick_coord(input logic [31:0] near);
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2, 3, 4, 5: return near + 32'($signed($urandom_range(0, 65536 * 8)) - 65536 * 4);
         6: return near;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_request(input logic [31:0] cx, input logic [31:0] cz,
                               input logic [31:0] px, input logic [31:0] pz);
      req_tvalid <= 1'b1;
      req_tdata  <= {pz, px, cz, cx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random();
      logic [31:0] cx, cz;
      cx = $urandom;
      cz = $urandom;
      send_request(cx, cz, pick_coord(cx), pick_coord(cz));
   endtask

   task automatic pause_sender(input int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Registers are only touched with the pipeline empty.
   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (PIPE_DEPTH + 4) @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Response side: random backpressure with quiet stretches.
   initial begin
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(negedge clock);
         if ($urandom_range(0, 3) != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap_length() + 1) @(negedge clock);
         end
      end
   end

   // Watchdog: too long without any accepted request or response.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || stim_done)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      logic [31:0] peak_set [6];
      logic [31:0] spread_set [6];
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_index  = REG_PEAK_MAGNITUDE;
      csr_wdata  = '0;
      stim_done  = 1'b0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // Directed part at reset settings: zero distance, extremes and saturation of d2,
      // the far tail where the exponent is cut to zero.
      send_request(0, 0, 0, 0);
      send_request(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      send_request(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
      send_request(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
      send_request(0, 0, 32'h0001_0000, 0);
      send_request(0, 0, 32'h0000_0001, 32'hffff_ffff);
      send_request(32'h0001_0000, 0, 0, 32'h0001_0000);
      send_request(0, 0, 32'h0004_e000, 0);
      send_request(0, 0, 32'h0004_f000, 0);
      send_request(0, 0, 32'h0010_0000, 32'h0010_0000);
      send_request(32'hffff_0000, 32'h0000_8000, 32'h0000_8000, 32'hffff_0000);

      // Zero variance, extreme magnitudes, then the widest variance.
      drain_pipeline();
      write_csr(REG_SPREAD_VARIANCE, 0);
      write_csr(REG_PEAK_MAGNITUDE, 32'h8000_0000);
      send_request(5, 5, 5, 5);
      send_request(0, 0, 1, 0);
      send_request(0, 0, 32'h0000_0010, 0);
      send_request(0, 0, 32'h0001_0000, 0);
      drain_pipeline();
      write_csr(REG_SPREAD_VARIANCE, 32'h7fff_ffff);
      write_csr(REG_PEAK_MAGNITUDE, 32'h7fff_ffff);
      send_request(0, 0, 0, 0);
      send_request(0, 0, 32'h7fff_ffff, 32'h7fff_ffff);
      send_request(32'h8000_0000, 0, 32'h7fff_ffff, 0);
      send_request(0, 0, 32'h0100_0000, 32'h0100_0000);

      peak_set   = '{32'h0001_0000, 32'h8000_0000, 32'h7fff_ffff, 32'hfffe_8000, 0, 32'h0000_0001};
      spread_set = '{32'h0001_0000, 0, 32'h7fff_ffff, 32'h0000_0042, 32'h0040_0000, 1};

      // Random part in phases, each with its own register setting.
      for (int phase = 0; phase < 8; phase++) begin
         drain_pipeline();
         if (phase < 6) begin
            write_csr(REG_PEAK_MAGNITUDE, peak_set[phase]);
            write_csr(REG_SPREAD_VARIANCE, spread_set[phase]);
         end else begin
            write_csr(REG_PEAK_MAGNITUDE, $urandom);
            write_csr(REG_SPREAD_VARIANCE, $urandom_range(0, 32'h0100_0000));
         end
         for (int n = 0; n < 205; n++) begin
            if ($urandom_range(0, 2) == 0 && n % 64 > 32) pause_sender(gap_length());
            if (n == 100 && phase == 3) begin
               req_tvalid <= 1'b0;
               while (pending_count != 0) @(negedge clock);
            end
            send_random();
         end
      end

      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      stim_done = 1'b1;
      repeat (PIPE_DEPTH + 10) @(negedge clock);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
`default_nettype wire

FILE: sim.f
rtl/core/grf_pkg.sv
rtl/core/gaussian_radial_falloff_core.sv
tb/grf_checker.sv
tb/tb.sv
